@@ rtl/core/pwmc_pkg.sv @@
// Shared types and constants for the PWM capture block.
package pwmc_pkg;

  // Register indexes on the configuration port.
  localparam logic [7:0] RegTimeoutMs     = 8'd0;
  localparam logic [7:0] RegStuckHighFull = 8'd1;
  localparam logic [7:0] RegMinPeriodUs   = 8'd2;
  localparam logic [7:0] RegMaxPeriodUs   = 8'd3;

  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 20;

  // Register reset values.
  localparam logic [15:0] TimeoutReset   = 16'd500;
  localparam logic [19:0] MinPeriodReset = 20'd100;
  localparam logic [19:0] MaxPeriodReset = 20'd1000000;

  // Scaling constants for the result fields.
  localparam logic [13:0] DutyFull   = 14'd10000;
  localparam logic [19:0] FreqMax    = 20'd1000000;
  localparam logic [19:0] FreqSatPer = 20'd100;
  localparam int          DivW       = 34;
  localparam int          DivSteps   = DivW / 2;
  localparam int          DivCntW    = $clog2(DivSteps);
  localparam logic [DivW-1:0] FreqNum = DivW'(100000000);

  // Input item.
  typedef struct packed {
    logic        req_type;
    logic        pin_level;
    logic [31:0] time_us;
    logic [31:0] time_ms;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [13:0] duty_hundredths;
    logic [19:0] freq_centihz;
    logic        present;
    logic [31:0] edge_age_ms;
    logic        timed_out;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_edge;
    logic take_poll;
    logic start_duty;
    logic start_freq;
    logic save_duty;
    logic save_freq;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic poll_div;
    logic div_done;
  } status_t;

endpackage

@@ rtl/core/pwmc_div.sv @@
// Restoring divider that retires two quotient bits per cycle.
module pwmc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pwmc_pkg::DivW-1:0]    dividend,
  input  logic [19:0]                  divisor,
  output logic                         done,
  output logic [pwmc_pkg::DivW-1:0]    quotient
);

  logic [pwmc_pkg::DivW-1:0]   quo;
  logic [19:0]                 rem;
  logic [19:0]                 dsr;
  logic [pwmc_pkg::DivCntW-1:0] cnt;
  logic                        busy;

  logic [20:0] trial1;
  logic [20:0] trial2;
  logic [19:0] rem1;
  logic [19:0] rem2;
  logic        bit1;
  logic        bit2;

  // Two conditional subtract steps on the partial remainder.
  always_comb begin
    trial1 = {rem, quo[pwmc_pkg::DivW-1]};
    bit1   = trial1 >= {1'b0, dsr};
    rem1   = bit1 ? 20'(trial1 - {1'b0, dsr}) : trial1[19:0];
    trial2 = {rem1, quo[pwmc_pkg::DivW-2]};
    bit2   = trial2 >= {1'b0, dsr};
    rem2   = bit2 ? 20'(trial2 - {1'b0, dsr}) : trial2[19:0];
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        quo <= {quo[pwmc_pkg::DivW-3:0], bit1, bit2};
        rem <= rem2;
        cnt <= cnt + 1'b1;
        if (cnt == pwmc_pkg::DivCntW'(pwmc_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/pwmc_dp.sv @@
// Datapath: configuration, capture state, poll evaluation and result register.
module pwmc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pwmc_pkg::req_t                    req_data,
  input  logic                              cfg_we,
  input  logic [pwmc_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [pwmc_pkg::CfgDataW-1:0]     cfg_wdata,
  input  pwmc_pkg::cmd_t                    cmd,
  output pwmc_pkg::status_t                 st,
  output pwmc_pkg::rsp_t                    rsp_data
);

  // Configuration registers.
  logic [15:0] timeout_ms;
  logic        stuck_high_full;
  logic [19:0] min_period_us;
  logic [19:0] max_period_us;

  // Capture state.
  logic [31:0] rise_stamp;
  logic [31:0] fall_stamp;
  logic [19:0] valid_period;
  logic [19:0] valid_high;
  logic        new_edge_seen;
  logic [31:0] last_edge_ms;
  logic        loss_latch;

  // Pending result fields.
  logic [13:0] res_duty;
  logic [19:0] res_freq;
  logic        res_present;
  logic [31:0] res_age;
  logic        res_timed_out;

  // Edge evaluation.
  logic [31:0] period;
  logic [31:0] high_time;
  logic        cycle_ok;

  // Poll evaluation.
  logic [31:0] last_next;
  logic [31:0] age_raw;
  logic [31:0] timeout_ext;
  logic        lost;
  logic        full_level;
  logic [31:0] age_out;

  // Divider interface.
  logic [pwmc_pkg::DivW-1:0] div_dividend;
  logic [pwmc_pkg::DivW-1:0] div_quotient;
  logic                      div_done;
  logic [13:0]               duty_q;

  always_comb begin
    period    = req_data.time_us - rise_stamp;
    high_time = fall_stamp - rise_stamp;
    cycle_ok  = (period >= {12'd0, min_period_us}) && (period <= {12'd0, max_period_us}) &&
                (high_time <= period);
  end

  always_comb begin
    last_next   = new_edge_seen ? req_data.time_ms : last_edge_ms;
    age_raw     = req_data.time_ms - last_next;
    timeout_ext = {16'd0, timeout_ms};
    lost        = (loss_latch && !new_edge_seen) || (age_raw >= timeout_ext);
    full_level  = req_data.pin_level && stuck_high_full;
    age_out     = (lost && (age_raw < timeout_ext)) ? timeout_ext : age_raw;
  end

  assign st.poll_div = !lost && (valid_period != 20'd0);
  assign st.div_done = div_done;

  // The product of the high time and the duty scale is the duty dividend.
  assign div_dividend = cmd.start_duty ?
                        pwmc_pkg::DivW'(valid_high) * pwmc_pkg::DivW'(pwmc_pkg::DutyFull) :
                        pwmc_pkg::FreqNum;

  pwmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_duty || cmd.start_freq),
    .dividend (div_dividend),
    .divisor  (valid_period),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign duty_q = (div_quotient > pwmc_pkg::DivW'(pwmc_pkg::DutyFull)) ?
                  pwmc_pkg::DutyFull : div_quotient[13:0];

  // Configuration writes and capture state.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms      <= pwmc_pkg::TimeoutReset;
      stuck_high_full <= 1'b0;
      min_period_us   <= pwmc_pkg::MinPeriodReset;
      max_period_us   <= pwmc_pkg::MaxPeriodReset;
      rise_stamp      <= '0;
      fall_stamp      <= '0;
      valid_period    <= '0;
      valid_high      <= '0;
      new_edge_seen   <= 1'b0;
      last_edge_ms    <= '0;
      loss_latch      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pwmc_pkg::RegTimeoutMs:     timeout_ms      <= cfg_wdata[15:0];
          pwmc_pkg::RegStuckHighFull: stuck_high_full <= cfg_wdata[0];
          pwmc_pkg::RegMinPeriodUs:   min_period_us   <= cfg_wdata;
          pwmc_pkg::RegMaxPeriodUs:   max_period_us   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.take_edge) begin
        new_edge_seen <= 1'b1;
        if (req_data.pin_level) begin
          rise_stamp <= req_data.time_us;
          if (cycle_ok) begin
            valid_period <= period[19:0];
            valid_high   <= high_time[19:0];
          end
        end else begin
          fall_stamp <= req_data.time_us;
        end
      end
      if (cmd.take_poll) begin
        new_edge_seen <= 1'b0;
        last_edge_ms  <= last_next;
        loss_latch    <= lost;
        if (lost) begin
          valid_period <= '0;
          valid_high   <= '0;
        end
      end
    end
  end

  // Pending result fields and the output register.
  always_ff @(posedge clk) begin
    if (cmd.take_poll) begin
      res_age       <= age_out;
      res_timed_out <= lost;
      res_freq      <= '0;
      if (lost) begin
        res_present <= full_level;
        res_duty    <= full_level ? pwmc_pkg::DutyFull : 14'd0;
      end else begin
        res_present <= valid_period != 20'd0;
        res_duty    <= '0;
      end
    end
    if (cmd.save_duty) begin
      res_duty <= duty_q;
    end
    if (cmd.save_freq) begin
      res_freq <= (valid_period < pwmc_pkg::FreqSatPer) ? pwmc_pkg::FreqMax :
                  div_quotient[19:0];
    end
    if (cmd.load_out) begin
      rsp_data.duty_hundredths <= res_duty;
      rsp_data.freq_centihz    <= res_freq;
      rsp_data.present         <= res_present;
      rsp_data.edge_age_ms     <= res_age;
      rsp_data.timed_out       <= res_timed_out;
    end
  end

endmodule

@@ rtl/core/pwmc_ctrl.sv @@
// Controller: sequences edge capture, poll evaluation, divisions and result transfer.
module pwmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_type,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  pwmc_pkg::status_t st,
  output pwmc_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DUTY,
    FREQ,
    PUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.take_edge  = accept && !req_type;
    cmd.take_poll  = accept && req_type;
    case (state)
      IDLE: begin
        if (cmd.take_poll) begin
          if (st.poll_div) begin
            cmd.start_duty = 1'b1;
            state_next     = DUTY;
          end else begin
            state_next = PUSH;
          end
        end
      end
      DUTY: begin
        if (st.div_done) begin
          cmd.save_duty  = 1'b1;
          cmd.start_freq = 1'b1;
          state_next     = FREQ;
        end
      end
      FREQ: begin
        if (st.div_done) begin
          cmd.save_freq = 1'b1;
          state_next    = PUSH;
        end
      end
      PUSH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // State and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/pwm_capture_with_timeout.sv @@
// An edge transfer is absorbed without leaving the idle state and gives no result.
// A poll gives one result, which goes straight to the output load when no cycle is stored or the
// signal is lost, and otherwise follows two passes of the shared radix-4 divider (a load
// and 17 steps); the output load waits until the output register is free.
// One item is in work at a time: a poll holds the input until its result is loaded, and the next
// item is taken while a result waits for transfer.
// Synchronous reset restores the register defaults and clears all capture state.
module pwm_capture_with_timeout (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  pwmc_pkg::req_t                 req_data,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output pwmc_pkg::rsp_t                 rsp_data,
  input  logic                           cfg_we,
  input  logic [pwmc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pwmc_pkg::CfgDataW-1:0]  cfg_wdata
);

  pwmc_pkg::cmd_t    cmd;
  pwmc_pkg::status_t st;

  pwmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .st        (st),
    .cmd       (cmd)
  );

  pwmc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .rsp_data  (rsp_data)
  );

endmodule
